// ===== rtl/bsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometric sensor compensation package
// Field widths, calibration register indexes and the fixed constants of the
// first-order compensation.
// ----------------------------------------------------------------------------
package bsc_pkg;

    // Raw conversion and calibration word widths.
    localparam int RAW_W   = 24;
    localparam int COEF_W  = 16;
    localparam int CIDX_W  = 3;

    // Result field widths.
    localparam int TEMP_W  = 19;
    localparam int PRES_W  = 24;

    // Stream data widths, padded to whole bytes.
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    // Calibration register indexes.
    localparam logic [CIDX_W-1:0] CFG_SENS_C1 = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_OFF_C2  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_TCS_C3  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_TCO_C4  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_TREF_C5 = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_TEMP_C6 = 3'd5;

    // Temperature at the reference point, in hundredths of a degree.
    localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;

    // Pressure saturation limits.
    localparam logic signed [PRES_W-1:0] PRES_MAX = 24'sh7FFFFF;
    localparam logic signed [PRES_W-1:0] PRES_MIN = 24'sh800000;

endpackage

// ===== rtl/barometric_sensor_compensation_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometric sensor compensation, first-order scheme
// Turns a raw pressure and temperature conversion pair into temperature in
// hundredths of a degree and pressure in hundredths of a millibar.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Content
//  s stream | in        | tdata[23:0] raw_pressure, tdata[47:24] raw_temperature
//  m stream | out       | tdata[18:0] temperature_centi, tdata[42:19] pressure_centi
//  cfg      | in        | write enable, index 0..5, 16-bit calibration word
//
//  Six register stages: one transaction per cycle when the output side
//  does not stall.
//  Depth is set by the 24 x 35 bit pressure product, split in two partial
//  products, and the wide adds around it.
//  Each stage holds its item until the next stage has room, so bubbles close
//  up under an output stall. Synchronous reset clears the valid bits and the
//  calibration words; the stage data registers are not reset.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Calibration write port.
    input  logic                         i_cfg_we,
    input  logic [bsc_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  logic [bsc_pkg::COEF_W-1:0]   i_cfg_data,
    // Input stream: [23:0] raw_pressure, [47:24] raw_temperature.
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [bsc_pkg::S_DATA_W-1:0] i_s_tdata,
    // Output stream: [18:0] temperature_centi, [42:19] pressure_centi, rest zero.
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [bsc_pkg::M_DATA_W-1:0] o_m_tdata
);
    import bsc_pkg::*;

    localparam int NSTG = 6;

    // Calibration words.
    logic [COEF_W-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    // Valid bits, one per stage, and the ready chain.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_rdy;

    // Stage payloads.
    logic [RAW_W-1:0]          r_d1_s1, r_d1_s2, r_d1_s3;
    logic signed [24:0]        r_dt;
    logic signed [40:0]        r_p6, r_p4, r_p3;
    logic signed [TEMP_W-1:0]  r_temp_s3, r_temp_s4, r_temp_s5, r_temp_s6;
    logic signed [35:0]        r_off_s3, r_off_s4, r_off_s5;
    logic signed [34:0]        r_sens;
    logic [41:0]               r_pp_lo;
    logic signed [41:0]        r_pp_hi;
    logic signed [59:0]        r_prod;
    logic signed [PRES_W-1:0]  r_pres;

    // Next values.
    logic signed [24:0]        n_dt;
    logic signed [TEMP_W-1:0]  n_temp;
    logic signed [35:0]        n_off;
    logic signed [34:0]        n_sens;
    logic signed [59:0]        n_prod;
    logic signed [39:0]        w_diff;
    logic signed [24:0]        w_pres_wide;
    logic signed [PRES_W-1:0]  n_pres;

    // Calibration register writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SENS_C1: r_c1 <= i_cfg_data;
                CFG_OFF_C2:  r_c2 <= i_cfg_data;
                CFG_TCS_C3:  r_c3 <= i_cfg_data;
                CFG_TCO_C4:  r_c4 <= i_cfg_data;
                CFG_TREF_C5: r_c5 <= i_cfg_data;
                CFG_TEMP_C6: r_c6 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage can take an item when it is empty or its item moves on.
    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_s_tready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: temperature difference from the reference.
    assign n_dt = $signed({1'b0, i_s_tdata[47:24]}) - $signed({1'b0, r_c5, 8'h00});

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_dt    <= n_dt;
            r_d1_s1 <= i_s_tdata[23:0];
        end
    end

    // Stage 2: the three coefficient products of the difference.
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_p6    <= r_dt * $signed({1'b0, r_c6});
            r_p4    <= r_dt * $signed({1'b0, r_c4});
            r_p3    <= r_dt * $signed({1'b0, r_c3});
            r_d1_s2 <= r_d1_s1;
        end
    end

    // Stage 3: temperature, offset and sensitivity. The temperature cannot
    // leave its field, since the scaled product stays within 18 bits.
    assign n_temp = $signed({r_p6[40], r_p6[40:23]}) + TEMP_BASE;
    assign n_off  = $signed({3'b000, r_c2, 17'h00000}) + $signed({r_p4[40], r_p4[40:6]});
    assign n_sens = $signed({3'b000, r_c1, 16'h0000}) + $signed({r_p3[40], r_p3[40:7]});

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_temp_s3 <= n_temp;
            r_off_s3  <= n_off;
            r_sens    <= n_sens;
            r_d1_s3   <= r_d1_s2;
        end
    end

    // Stage 4: pressure product split on bit 18 of the sensitivity.
    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_pp_lo   <= {18'h00000, r_d1_s3} * {24'h000000, r_sens[17:0]};
            r_pp_hi   <= $signed({1'b0, r_d1_s3}) * $signed(r_sens[34:18]);
            r_temp_s4 <= r_temp_s3;
            r_off_s4  <= r_off_s3;
        end
    end

    // Stage 5: combine the partial products.
    assign n_prod = $signed({r_pp_hi[41:0], 18'h00000}) + $signed({18'h00000, r_pp_lo});

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_prod    <= n_prod;
            r_temp_s5 <= r_temp_s4;
            r_off_s5  <= r_off_s4;
        end
    end

    // Stage 6: remove the offset, scale and saturate the pressure.
    assign w_diff      = $signed({r_prod[59], r_prod[59:21]})
                         - $signed({{4{r_off_s5[35]}}, r_off_s5});
    assign w_pres_wide = w_diff[39:15];

    always_comb begin
        if (w_pres_wide[24] != w_pres_wide[23]) begin
            n_pres = w_pres_wide[24] ? PRES_MIN : PRES_MAX;
        end else begin
            n_pres = w_pres_wide[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r_pres    <= n_pres;
            r_temp_s6 <= r_temp_s5;
        end
    end

    // Output transaction.
    assign o_m_tvalid = r_vld[NSTG-1];
    assign o_m_tdata  = {5'b00000, r_pres, r_temp_s6};

endmodule

// ===== rtl/bsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometric sensor compensation port checker
// Watches the top level ports for stall, reset and result range behavior.
// ----------------------------------------------------------------------------
module bsc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_s_tready,
    input logic                         o_m_tvalid,
    input logic                         i_m_tready,
    input logic [bsc_pkg::M_DATA_W-1:0] o_m_tdata
);
    import bsc_pkg::*;

    logic signed [TEMP_W-1:0] w_temp;
    assign w_temp = o_m_tdata[TEMP_W-1:0];

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled output transaction changed");

    // The input side only blocks when a result is waiting at the output.
    a_ready_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input blocked with output free");

    // Padding bits stay zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[M_DATA_W-1:TEMP_W+PRES_W] == '0)
        else $error("padding bits set");

    // Temperature lies within the reach of the scaled 41-bit product.
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_temp >= -19'sd129072) && (w_temp <= 19'sd133071))
        else $error("temperature out of reach");

endmodule

bind barometric_sensor_compensation_top bsc_checker u_bsc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== tb/barometric_sensor_compensation_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometric sensor compensation testbench
// Drives raw pressure and temperature pairs into the compensation pipeline
// under several calibration sets and compares every compensated reading with
// a 64-bit integer model kept in the bench. A short table of directed pairs
// comes first, then random pairs with random pacing and stalls on both sides.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_top_tb;

    import bsc_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_ITEMS   = 85;
    localparam int DIRECTED_ROWS = 19;
    localparam int MAX_REPORTS   = 10;

    // Write indexes past the last calibration word; the block ignores them.
    localparam logic [CIDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam longint TEMP_FLOOR = -262144;
    localparam longint TEMP_CEIL  = 262143;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic signed [PRES_W-1:0] pres;
    } reading_t;

    // One directed pair: calibration set, raw pressure, raw temperature and,
    // where it is obvious, the reading that must come out.
    typedef struct packed {
        logic [2:0]               cal_set;
        logic [RAW_W-1:0]         raw_p;
        logic [RAW_W-1:0]         raw_t;
        logic                     known;
        logic signed [TEMP_W-1:0] temp;
        logic signed [PRES_W-1:0] pres;
    } stim_row_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CIDX_W-1:0]     cfg_idx     = '0;
    logic [COEF_W-1:0]     cfg_data    = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    // Calibration words as the block should hold them.
    logic [COEF_W-1:0] coef_sens   = '0;
    logic [COEF_W-1:0] coef_off    = '0;
    logic [COEF_W-1:0] coef_tcs    = '0;
    logic [COEF_W-1:0] coef_tco    = '0;
    logic [COEF_W-1:0] coef_tref   = '0;
    logic [COEF_W-1:0] coef_tslope = '0;

    reading_t pending_readings [$];
    int       error_count   = 0;
    int       cycle_count   = 0;
    logic     sink_throttle = 1'b0;
    logic     hold_req      = 1'b0;
    int       stall_left    = 0;
    int       run_left      = 0;

    // Set 0 is the reset state and is never written.
    logic [COEF_W-1:0] cal_sets [5][6] = '{
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
        '{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165},
        '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF},
        '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000}
    };

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // Reset calibration: all words zero, so every pair reads 20.00 C, 0.
        '{3'd0, 24'h000000, 24'h000000, 1'b1, 19'sd2000, 24'sd0},
        '{3'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 19'sd2000, 24'sd0},
        '{3'd0, 24'hFFFFFF, 24'h000000, 1'b1, 19'sd2000, 24'sd0},
        '{3'd0, 24'h000000, 24'hFFFFFF, 1'b1, 19'sd2000, 24'sd0},
        // All words at full scale; zero temperature difference gives -OFF.
        '{3'd1, 24'h000000, 24'hFFFF00, 1'b1, 19'sd2000, -24'sd262140},
        '{3'd1, 24'h000000, 24'h000000, 1'b0, 19'sd0, 24'sd0},
        '{3'd1, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 19'sd0, 24'sd0},
        '{3'd1, 24'hFFFFFF, 24'h000000, 1'b0, 19'sd0, 24'sd0},
        '{3'd1, 24'h800000, 24'h7FFF00, 1'b0, 19'sd0, 24'sd0},
        // Typical calibration, with the classic conversion pair.
        '{3'd2, 24'd6465444, 24'd8077636, 1'b0, 19'sd0, 24'sd0},
        '{3'd2, 24'd6465444, 24'd8077568, 1'b0, 19'sd0, 24'sd0},
        '{3'd2, 24'h000000, 24'h000000, 1'b0, 19'sd0, 24'sd0},
        '{3'd2, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 19'sd0, 24'sd0},
        // Sensitivity and slope at full scale, no offset, zero reference.
        '{3'd3, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 19'sd0, 24'sd0},
        '{3'd3, 24'h000001, 24'h000000, 1'b0, 19'sd0, 24'sd0},
        '{3'd3, 24'hFFFFFF, 24'h000001, 1'b0, 19'sd0, 24'sd0},
        // Offset only, large reference: strongly negative pressure.
        '{3'd4, 24'hABCDEF, 24'hFFFF00, 1'b1, 19'sd2000, -24'sd262140},
        '{3'd4, 24'hFFFFFF, 24'h000000, 1'b0, 19'sd0, 24'sd0},
        '{3'd4, 24'h000000, 24'h000000, 1'b0, 19'sd0, 24'sd0}
    };

    barometric_sensor_compensation_top u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),     // [23:0] raw_pressure, [47:24] raw_temperature
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)      // [18:0] temperature_centi, [42:19] pressure_centi
    );

    // 100 MHz clock.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // First-order compensation in signed 64-bit arithmetic with floor shifts.
    function automatic reading_t compensate_reading(input logic [RAW_W-1:0] raw_p,
                                                    input logic [RAW_W-1:0] raw_t);
        longint press_raw, temp_raw, c_sens, c_off, c_tcs, c_tco, c_tref, c_tslope;
        longint d_temp, temp_full, offset, sens, pres_full;
        reading_t r;
        press_raw = {40'd0, raw_p};
        temp_raw  = {40'd0, raw_t};
        c_sens    = {48'd0, coef_sens};
        c_off     = {48'd0, coef_off};
        c_tcs     = {48'd0, coef_tcs};
        c_tco     = {48'd0, coef_tco};
        c_tref    = {48'd0, coef_tref};
        c_tslope  = {48'd0, coef_tslope};
        d_temp    = temp_raw - (c_tref <<< 8);
        temp_full = TEMP_BASE + ((d_temp * c_tslope) >>> 23);
        offset    = (c_off <<< 17) + ((c_tco * d_temp) >>> 6);
        sens      = (c_sens <<< 16) + ((c_tcs * d_temp) >>> 7);
        pres_full = (((press_raw * sens) >>> 21) - offset) >>> 15;
        // Saturate to the field ranges.
        if (temp_full < TEMP_FLOOR) temp_full = TEMP_FLOOR;
        if (temp_full > TEMP_CEIL)  temp_full = TEMP_CEIL;
        if (pres_full < PRES_MIN)   pres_full = PRES_MIN;
        if (pres_full > PRES_MAX)   pres_full = PRES_MAX;
        r.temp = temp_full[TEMP_W-1:0];
        r.pres = pres_full[PRES_W-1:0];
        return r;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Calibration word with a bias toward the range ends.
    function automatic logic [COEF_W-1:0] pick_coef();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return COEF_W'($urandom);
    endfunction

    // One write transaction; the model copy follows the same index decode.
    task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_SENS_C1: coef_sens   = data;
            CFG_OFF_C2:  coef_off    = data;
            CFG_TCS_C3:  coef_tcs    = data;
            CFG_TCO_C4:  coef_tco    = data;
            CFG_TREF_C5: coef_tref   = data;
            CFG_TEMP_C6: coef_tslope = data;
            default: ;
        endcase
    endtask

    // Loads all six words, with a write to an unused index in between.
    task automatic program_calibration(input logic [COEF_W-1:0] c1, c2, c3, c4, c5, c6);
        cfg_write(CFG_SENS_C1, c1);
        cfg_write(CFG_OFF_C2, c2);
        cfg_write(CFG_TCS_C3, c3);
        cfg_write($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, COEF_W'($urandom));
        cfg_write(CFG_TCO_C4, c4);
        cfg_write(CFG_TREF_C5, c5);
        cfg_write(CFG_TEMP_C6, c6);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offers one pair and queues its reading once the transaction completes.
    task automatic push_sample(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t,
                               input logic known, input reading_t typed);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {raw_t, raw_p};
        do @(posedge clk); while (!s_tready);
        pending_readings.push_back(known ? typed : compensate_reading(raw_p, raw_t));
    endtask

    task automatic idle_source(input int cycles);
        if (cycles > 0) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
    endtask

    // Output pacing: random stalls, or always ready, and a long hold on request.
    always @(negedge clk) begin : sink_pacing
        logic nxt;
        if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = LONG_HOLD;
        end
        if (stall_left > 0) begin
            stall_left--;
            nxt = 1'b0;
        end else if (!sink_throttle || run_left > 0) begin
            if (run_left > 0) run_left--;
            nxt = 1'b1;
        end else begin
            stall_left = pick_gap();
            run_left   = $urandom_range(1, 20);
            if (stall_left > 0) begin
                stall_left--;
                nxt = 1'b0;
            end else begin
                nxt = 1'b1;
            end
        end
        m_tready <= nxt;
    end

    // Compare each output transaction with the oldest queued reading.
    always @(posedge clk) begin : result_check
        reading_t           want;
        logic signed [TEMP_W-1:0] got_temp;
        logic signed [PRES_W-1:0] got_pres;
        if (rst_n && m_tvalid && m_tready) begin
            got_temp = m_tdata[TEMP_W-1:0];
            got_pres = m_tdata[TEMP_W+PRES_W-1:TEMP_W];
            if (pending_readings.size() == 0) begin
                flag_error($sformatf("unexpected reading temp=%0d pres=%0d",
                                     got_temp, got_pres));
            end else begin
                want = pending_readings.pop_front();
                if (got_temp !== want.temp)
                    flag_error($sformatf("temperature_centi exp=%0d got=%0d",
                                         want.temp, got_temp));
                if (got_pres !== want.pres)
                    flag_error($sformatf("pressure_centi exp=%0d got=%0d",
                                         want.pres, got_pres));
                if (m_tdata[M_DATA_W-1:TEMP_W+PRES_W] !== '0)
                    flag_error($sformatf("padding bits not zero: %h",
                                         m_tdata[M_DATA_W-1:TEMP_W+PRES_W]));
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus: reset, directed table, then random phases.
    initial begin : stimulus
        int              cur_set;
        logic [RAW_W-1:0] raw_p, raw_t;
        int              near_ref;
        logic            src_throttle;
        reading_t        typed;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed pairs, grouped by calibration set.
        cur_set = 0;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].cal_set != cur_set) begin
                cur_set = directed_rows[i].cal_set;
                wait_drained();
                program_calibration(cal_sets[cur_set][0], cal_sets[cur_set][1],
                                    cal_sets[cur_set][2], cal_sets[cur_set][3],
                                    cal_sets[cur_set][4], cal_sets[cur_set][5]);
            end
            typed.temp = directed_rows[i].temp;
            typed.pres = directed_rows[i].pres;
            push_sample(directed_rows[i].raw_p, directed_rows[i].raw_t,
                        directed_rows[i].known, typed);
            idle_source(pick_gap());
        end

        // Random phases; phase 0 runs with no idling at all, phase 2 starts
        // with a long output hold while pairs keep coming.
        typed = '0;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained();
            if (ph == 4)
                program_calibration('1, '1, '1, '1, '1, '1);
            else if (ph == 5)
                program_calibration('0, '0, '0, '0, '0, '0);
            else
                program_calibration(pick_coef(), pick_coef(), pick_coef(),
                                    pick_coef(), pick_coef(), pick_coef());
            src_throttle  = (ph != 0 && ph != 2);
            sink_throttle = (ph != 0);
            if (ph == 2) hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                raw_p = RAW_W'($urandom);
                raw_t = RAW_W'($urandom);
                case ($urandom_range(0, 9))
                    6: begin
                        // Temperature close to the reference point.
                        near_ref = int'(coef_tref) * 256 + $urandom_range(0, 1023) - 512;
                        if (near_ref < 0) near_ref = 0;
                        if (near_ref > 16777215) near_ref = 16777215;
                        raw_t = near_ref[RAW_W-1:0];
                    end
                    7: raw_p = $urandom_range(0, 1) ? '1 : '0;
                    8: raw_t = $urandom_range(0, 1) ? '1 : '0;
                    9: begin
                        raw_p = $urandom_range(0, 1) ? '1 : '0;
                        raw_t = $urandom_range(0, 1) ? '1 : '0;
                    end
                    default: ;
                endcase
                push_sample(raw_p, raw_t, 1'b0, typed);
                if (ph == 3 && i == PHASE_ITEMS / 2)
                    wait_drained();
                else
                    idle_source(src_throttle ? pick_gap() : 0);
            end
        end

        // Let the pipeline empty, then watch for stray output.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_readings.size() != 0)
            flag_error($sformatf("%0d readings never arrived", pending_readings.size()));
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
